FILE: design/imuct_pkg.sv
package imuct_pkg;

  localparam int AngleFracBits = 16;
  localparam int CordicSteps   = 16;
  localparam int StepW         = $clog2(CordicSteps);

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
  } imu_in_t;

  typedef struct packed {
    logic signed [15:0] pitch_deg;
    logic signed [15:0] roll_deg;
  } imu_out_t;

  typedef enum logic [1:0] {
    RegGyroScale  = 2'd0,
    RegTimeStep   = 2'd1,
    RegBlendWeight = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    StIdle, StRate, StInc, StSum, StPrep, StCordic, StBlendMul, StBlendAdd, StNext, StOut
  } state_e;

  typedef struct packed {
    logic   load;
    logic   axis;
    state_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic cordic_done;
  } dp_sts_t;

  // atan(2^-i) in degrees, Q.32
  function automatic logic [37:0] atan_lut(input logic [StepW-1:0] i);
    logic [37:0] t [0:23];
    t[0]  = 38'd193273528320; t[1]  = 38'd114096026023; t[2]  = 38'd60285206654;
    t[3]  = 38'd30601712202;  t[4]  = 38'd15360239180;  t[5]  = 38'd7687607525;
    t[6]  = 38'd3844741809;   t[7]  = 38'd1922488225;   t[8]  = 38'd961258779;
    t[9]  = 38'd480631223;    t[10] = 38'd240315841;    t[11] = 38'd120157949;
    t[12] = 38'd60078978;     t[13] = 38'd30039489;     t[14] = 38'd15019744;
    t[15] = 38'd7509872;      t[16] = 38'd3754936;      t[17] = 38'd1877468;
    t[18] = 38'd938734;       t[19] = 38'd469367;       t[20] = 38'd234683;
    t[21] = 38'd117341;       t[22] = 38'd58670;        t[23] = 38'd29335;
    return t[i];
  endfunction

endpackage

FILE: design/imuct_ctrl.sv
module imuct_ctrl import imuct_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);
  state_e state_q, state_d;
  logic   axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.axis = axis_q;
    cmd_o.op   = state_q;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          axis_d  = 1'b0;
          state_d = StRate;
        end
      end
      StRate:     state_d = StInc;
      StInc:      state_d = StSum;
      StSum:      state_d = StPrep;
      StPrep:     state_d = StCordic;
      StCordic:   if (sts_i.cordic_done) state_d = StBlendMul;
      StBlendMul: state_d = StBlendAdd;
      StBlendAdd: state_d = StNext;
      StNext: begin
        if (axis_q) state_d = StOut;
        else begin
          axis_d  = 1'b1;
          state_d = StPrep;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

FILE: design/imuct_dp.sv
module imuct_dp import imuct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  imu_in_t     in_i,
  input  logic [15:0] gyro_scale_i,
  input  logic [15:0] time_step_i,
  input  logic [16:0] blend_weight_i,
  output dp_sts_t     sts_o,
  output imu_out_t    out_o
);
  localparam longint AMax = 64'sd2147483647;
  localparam longint AMin = -64'sd2147483648;

  imu_in_t smp_q;
  logic signed [31:0] pitch_q, roll_q;
  logic signed [32:0] rp_q, rr_q;       // products then rates
  logic signed [49:0] ip_q, ir_q;       // increments, Q.16
  logic signed [37:0] cx_q, cy_q;       // cordic vector
  logic signed [40:0] cz_q;             // degrees Q.32
  logic [StepW-1:0]   step_q;
  logic signed [31:0] tilt_q;
  logic signed [50:0] ma_q, mt_q;
  logic [16:0]        w_c;
  logic signed [31:0] cur_c;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > AMax) return 32'sh7fffffff;
    if (v < AMin) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [31:0] a);
    logic signed [31:0] d;
    d = a >>> AngleFracBits;
    if (a < 0 && a[AngleFracBits-1:0] != '0) d = d + 32'sd1;
    if (d > 32'sd32767) return 16'sh7fff;
    if (d < -32'sd32768) return 16'sh8000;
    return d[15:0];
  endfunction

  function automatic logic signed [32:0] trunc16(input logic signed [32:0] p);
    logic signed [32:0] q;
    q = p >>> 16;
    if (p < 0 && p[15:0] != '0) q = q + 33'sd1;
    return q;
  endfunction

  function automatic logic signed [49:0] fmt(input logic signed [49:0] q16);
    if (AngleFracBits >= 16) return q16 <<< (AngleFracBits - 16);
    return q16 >>> (16 - AngleFracBits);
  endfunction

  assign w_c   = blend_weight_i[16] ? 17'h10000 : blend_weight_i;
  assign cur_c = cmd_i.axis ? roll_q : pitch_q;
  assign sts_o.cordic_done = (step_q == StepW'(CordicSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= '0;
      roll_q  <= '0;
    end else begin
      case (cmd_i.op)
        StSum: begin
          pitch_q <= sat32(64'(pitch_q) + 64'(ip_q));
          roll_q  <= sat32(64'(roll_q) + 64'(ir_q));
        end
        StBlendAdd: begin
          if (cmd_i.axis) roll_q <= sat32(64'((ma_q + mt_q) >>> 16));
          else            pitch_q <= sat32(64'((ma_q + mt_q) >>> 16));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) smp_q <= in_i;
    case (cmd_i.op)
      StRate: begin
        rp_q <= 33'(smp_q.gyro_y) * 33'($signed({1'b0, gyro_scale_i}));
        rr_q <= 33'(smp_q.gyro_x) * 33'($signed({1'b0, gyro_scale_i}));
      end
      StInc: begin
        ip_q <= fmt(50'(trunc16(rp_q)) * 50'($signed({1'b0, time_step_i})));
        ir_q <= fmt(50'(trunc16(rr_q)) * 50'($signed({1'b0, time_step_i})));
      end
      StPrep: begin
        logic signed [37:0] x, y;
        x = 38'(smp_q.accel_z) <<< 16;
        y = (cmd_i.axis ? 38'(smp_q.accel_y) : 38'(smp_q.accel_x)) <<< 16;
        step_q <= '0;
        if (x < 0) begin
          if (y >= 0) begin cx_q <= y;  cy_q <= -x; cz_q <= 41'sd386547056640; end
          else        begin cx_q <= -y; cy_q <= x;  cz_q <= -41'sd386547056640; end
        end else begin
          cx_q <= x; cy_q <= y; cz_q <= '0;
        end
      end
      StCordic: begin
        logic signed [40:0] a;
        logic signed [40:0] zs;
        a = 41'($signed({1'b0, atan_lut(step_q)}));
        if (cy_q > 0) begin
          cx_q <= cx_q + (cy_q >>> step_q);
          cy_q <= cy_q - (cx_q >>> step_q);
          zs = cz_q + a;
        end else begin
          cx_q <= cx_q - (cy_q >>> step_q);
          cy_q <= cy_q + (cx_q >>> step_q);
          zs = cz_q - a;
        end
        cz_q <= zs;
        step_q <= step_q + 1'b1;
        if (sts_o.cordic_done) begin
          if (smp_q.accel_z == 0 &&
              (cmd_i.axis ? smp_q.accel_y == 0 : smp_q.accel_x == 0))
            tilt_q <= '0;
          else
            tilt_q <= sat32(64'(zs >>> (32 - AngleFracBits)));
        end
      end
      StBlendMul: begin
        ma_q <= 51'(cur_c) * 51'($signed({1'b0, w_c}));
        mt_q <= 51'(tilt_q) * 51'($signed({1'b0, 18'h10000 - 18'(w_c)}));
      end
      default: ;
    endcase
  end

  assign out_o.pitch_deg = to_out(pitch_q);
  assign out_o.roll_deg  = to_out(roll_q);
endmodule

FILE: design/imu_complementary_tilt_filter.sv
// Each sample is processed by two 16-step CORDIC runs, one per axis, on one shared
// vectoring unit.
// A new sample is accepted only after the previous result has been taken; output held until taken.
// Reset: asynchronous active low; angles clear to zero, registers to defaults.
module imu_complementary_tilt_filter import imuct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  imu_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output imu_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  logic [15:0] gyro_scale_q, time_step_q;
  logic [16:0] blend_weight_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_scale_q   <= 16'd573;
      time_step_q    <= 16'd655;
      blend_weight_q <= 17'd64225;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegGyroScale:   gyro_scale_q   <= cfg_data_i[15:0];
        RegTimeStep:    time_step_q    <= cfg_data_i[15:0];
        RegBlendWeight: blend_weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  imuct_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  imuct_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i(in_data_i),
    .gyro_scale_i(gyro_scale_q), .time_step_i(time_step_q),
    .blend_weight_i(blend_weight_q), .sts_o(sts), .out_o(out_data_o)
  );

  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
endmodule
